@@ design/fss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_pkg
// Shared codes, widths and control types of the fingerprint subset screen.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int CMD_W        = 2;
  localparam int WORD_W       = 32;
  localparam int WIDX_W       = 5;
  localparam int POS_W        = 32;
  localparam int ENTRY_NUM_W  = 12;
  localparam int STOP_W       = 13;
  localparam int CFG_W        = 6;
  localparam int CFG_IDX_W    = 1;
  localparam int MAX_SLOTS    = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic KIND_CAND = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CAND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORDS    = 1'b1;

  localparam logic [CFG_W-1:0] MAX_CAND_RST = 6'd63;
  localparam logic [CFG_W-1:0] WORDS_RST    = 6'd32;

  typedef struct packed {
    logic word_we;
    logic pos_we;
    logic rd_en;
  } fss_mem_ctl_t;

endpackage

@@ design/fss_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_store
// Entry word memory and entry position memory, one write, one registered read.
// ----------------------------------------------------------------------------
module fss_store #(
  parameter int NUM_ENTRIES = 4096,
  parameter int EIDX_W      = 12,
  parameter int SLOT_W      = 5
) (
  input  logic                      clk_i,
  input  fss_pkg::fss_mem_ctl_t     ctl_i,
  input  logic [EIDX_W-1:0]         wr_entry_i,
  input  logic [SLOT_W-1:0]         wr_slot_i,
  input  logic [fss_pkg::WORD_W-1:0] wr_word_i,
  input  logic [fss_pkg::POS_W-1:0]  wr_pos_i,
  input  logic [EIDX_W-1:0]         rd_entry_i,
  input  logic [SLOT_W-1:0]         rd_slot_i,
  output logic [fss_pkg::WORD_W-1:0] rd_word_o,
  output logic [fss_pkg::POS_W-1:0]  rd_pos_o
);
  import fss_pkg::*;

  localparam int WORD_DEPTH = NUM_ENTRIES * (2 ** SLOT_W);

  logic [WORD_W-1:0] word_mem [WORD_DEPTH];
  logic [POS_W-1:0]  pos_mem  [NUM_ENTRIES];
  logic [WORD_W-1:0] rd_word_q;
  logic [POS_W-1:0]  rd_pos_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.word_we) begin
      word_mem[{wr_entry_i, wr_slot_i}] <= wr_word_i;
    end
    if (ctl_i.pos_we) begin
      pos_mem[wr_entry_i] <= wr_pos_i;
    end
    if (ctl_i.rd_en) begin
      rd_word_q <= word_mem[{rd_entry_i, rd_slot_i}];
      rd_pos_q  <= pos_mem[rd_entry_i];
    end
  end

  assign rd_word_o = rd_word_q;
  assign rd_pos_o  = rd_pos_q;

endmodule

@@ design/fss_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_match
// Pattern fingerprint registers and the shared subset compare unit.
// ----------------------------------------------------------------------------
module fss_match #(
  parameter int SLOT_W = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pat_we_i,
  input  logic [SLOT_W-1:0]          pat_slot_i,
  input  logic [fss_pkg::WORD_W-1:0] pat_word_i,
  input  logic [SLOT_W-1:0]          cmp_slot_i,
  input  logic [fss_pkg::WORD_W-1:0] cmp_word_i,
  output logic                       hit_o
);
  import fss_pkg::*;

  localparam int DEPTH = 2 ** SLOT_W;

  logic [WORD_W-1:0] pat_q [DEPTH];
  logic [WORD_W-1:0] pat_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        pat_q[k] <= '0;
      end
    end else if (pat_we_i) begin
      pat_q[pat_slot_i] <= pat_word_i;
    end
  end

  // every set pattern bit must be set in the entry word
  assign pat_sel = pat_q[cmp_slot_i];
  assign hit_o   = (pat_sel & cmp_word_i) == pat_sel;

endmodule

@@ design/fingerprint_subset_screen_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fingerprint_subset_screen_top
// Fingerprint table with word-by-word entry loading and a subset screen scan.
// ----------------------------------------------------------------------------
// Pattern loads, entry adds and clears are done directly in the idle state. A
// search walks the table with one entry memory read port and one shared word
// compare: each entry passes an entry state, then a read state and a compare
// state per word compared, the scan leaves an entry at its first mismatching
// word, and every result word is held in the output register while the output
// is stalled. The input is stalled for the whole search. The entry memory
// holds no reset contents; words of an entry never written read back as
// whatever the memory holds.
module fingerprint_subset_screen_top #(
  parameter int FP_WORDS    = 32,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [fss_pkg::CMD_W-1:0]        command_i,
  input  logic [fss_pkg::WORD_W-1:0]       word_value_i,
  input  logic [fss_pkg::WIDX_W-1:0]       word_index_i,
  input  logic [fss_pkg::POS_W-1:0]        seek_position_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             kind_o,
  output logic [fss_pkg::POS_W-1:0]        found_position_o,
  output logic [fss_pkg::ENTRY_NUM_W-1:0]  entry_number_o,
  output logic [fss_pkg::STOP_W-1:0]       stop_index_o,
  output logic                             stopped_early_o,
  output logic                             last_o,
  input  logic                             cfg_we_i,
  input  logic [fss_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fss_pkg::CFG_W-1:0]        cfg_data_i
);
  import fss_pkg::*;

  localparam int EFF_MAX = (FP_WORDS < MAX_SLOTS) ? FP_WORDS : MAX_SLOTS;
  localparam int SLOT_W  = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
  localparam int EIDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ENT  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CFG_W-1:0]  max_cand_q, words_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [SLOT_W-1:0] j_q, j_d;
  logic [CFG_W-1:0]  found_q, found_d;

  logic                   out_valid_q, out_valid_d;
  logic                   kind_q, kind_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [ENTRY_NUM_W-1:0] num_q, num_d;
  logic [STOP_W-1:0]      stop_q, stop_d;
  logic                   early_q, early_d;
  logic                   last_q, last_d;

  logic [CFG_W-1:0]  w_eff, w_last, limit;
  logic              in_acc, idx_ok, idx_last, pat_we, hit;
  logic [31:0]       i_ext;
  logic [CFG_W-1:0]  j_ext;
  fss_mem_ctl_t      mem_ctl;
  logic [WORD_W-1:0] rd_word;
  logic [POS_W-1:0]  rd_pos;

  always_comb begin
    if (words_q == '0) begin
      w_eff = CFG_W'(1);
    end else if (words_q > CFG_W'(EFF_MAX)) begin
      w_eff = CFG_W'(EFF_MAX);
    end else begin
      w_eff = words_q;
    end
  end

  assign w_last   = w_eff - CFG_W'(1);
  assign limit    = (max_cand_q == '0) ? CFG_W'(1) : max_cand_q;
  assign idx_ok   = {1'b0, word_index_i} < w_eff;
  assign idx_last = {1'b0, word_index_i} == w_last;
  assign i_ext    = 32'(i_q);
  assign j_ext    = {{(CFG_W - SLOT_W){1'b0}}, j_q};

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cand_q <= MAX_CAND_RST;
      words_q    <= WORDS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_CAND: max_cand_q <= cfg_data_i;
        CFG_WORDS:    words_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    num_d       = num_q;
    stop_d      = stop_q;
    early_d     = early_q;
    last_d      = last_q;
    pat_we      = 1'b0;
    mem_ctl     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (command_i)
            CMD_LOAD: pat_we = idx_ok;
            CMD_ADD: begin
              if (idx_ok && (count_q < CNT_W'(MAX_ENTRIES))) begin
                mem_ctl.word_we = 1'b1;
                if (idx_last) begin
                  mem_ctl.pos_we = 1'b1;
                  count_d        = count_q + CNT_W'(1);
                end
              end
            end
            CMD_SEARCH: begin
              i_d     = '0;
              found_d = '0;
              state_d = ST_ENT;
            end
            CMD_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      ST_ENT: begin
        j_d = '0;
        if (i_q >= count_q) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_DONE;
          pos_d       = '0;
          num_d       = '0;
          stop_d      = i_ext[STOP_W-1:0];
          early_d     = 1'b0;
          last_d      = 1'b1;
          state_d     = ST_OUT;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        mem_ctl.rd_en = 1'b1;
        state_d       = ST_CMP;
      end
      ST_CMP: begin
        if (!hit) begin
          i_d     = i_q + CNT_W'(1);
          state_d = ST_ENT;
        end else if (j_ext == w_last) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_CAND;
          pos_d       = rd_pos;
          num_d       = i_ext[ENTRY_NUM_W-1:0];
          stop_d      = '0;
          early_d     = 1'b0;
          last_d      = 1'b0;
          found_d     = found_q + CFG_W'(1);
          state_d     = ST_OUT;
        end else begin
          j_d     = j_q + SLOT_W'(1);
          state_d = ST_RD;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            state_d = ST_IDLE;
          end else if (found_q >= limit) begin
            // limit reached: done word names the accepting entry
            out_valid_d = 1'b1;
            kind_d      = KIND_DONE;
            pos_d       = '0;
            num_d       = '0;
            stop_d      = i_ext[STOP_W-1:0];
            early_d     = 1'b1;
            last_d      = 1'b1;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = ST_ENT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      found_q     <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    pos_q   <= pos_d;
    num_q   <= num_d;
    stop_q  <= stop_d;
    early_q <= early_d;
  end

  fss_store #(
    .NUM_ENTRIES (MAX_ENTRIES),
    .EIDX_W      (EIDX_W),
    .SLOT_W      (SLOT_W)
  ) u_store (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .wr_entry_i (count_q[EIDX_W-1:0]),
    .wr_slot_i  (word_index_i[SLOT_W-1:0]),
    .wr_word_i  (word_value_i),
    .wr_pos_i   (seek_position_i),
    .rd_entry_i (i_q[EIDX_W-1:0]),
    .rd_slot_i  (j_q),
    .rd_word_o  (rd_word),
    .rd_pos_o   (rd_pos)
  );

  fss_match #(
    .SLOT_W (SLOT_W)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pat_we_i   (pat_we),
    .pat_slot_i (word_index_i[SLOT_W-1:0]),
    .pat_word_i (word_value_i),
    .cmp_slot_i (j_q),
    .cmp_word_i (rd_word),
    .hit_o      (hit)
  );

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign found_position_o = pos_q;
  assign entry_number_o   = num_q;
  assign stop_index_o     = stop_q;
  assign stopped_early_o  = early_q;
  assign last_o           = last_q;

endmodule

@@ design/fss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_checker
// Port-level checks of the screen's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module fss_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [fss_pkg::CMD_W-1:0]        command_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             kind_o,
  input logic [fss_pkg::POS_W-1:0]        found_position_o,
  input logic [fss_pkg::ENTRY_NUM_W-1:0]  entry_number_o,
  input logic [fss_pkg::STOP_W-1:0]       stop_index_o,
  input logic                             stopped_early_o,
  input logic                             last_o
);
  import fss_pkg::*;

  // done word closes the search, candidate words leave done fields clear
  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == KIND_DONE) ? (last_o && found_position_o == '0 &&
      entry_number_o == '0) : (!last_o && !stopped_early_o && stop_index_o == '0)))
    else $error("result word fields do not fit its kind");

  // no new input word while results are pending
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result waits");

  // an accepted search holds the input off
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && command_i == CMD_SEARCH) |=> in_stall_o)
    else $error("input not stalled after a search");

  // non-search words never produce results
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && command_i != CMD_SEARCH) |=> !out_valid_o)
    else $error("result word without a search");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(kind_o) &&
      $stable(found_position_o) && $stable(entry_number_o) &&
      $stable(stop_index_o) && $stable(stopped_early_o) && $stable(last_o)))
    else $error("stalled result word changed");

endmodule

bind fingerprint_subset_screen_top fss_checker u_fss_checker (.*);
